/* sv/hkb_pkg.sv */
// Package for the boot-keyboard report to scancode translator.
// Holds the usage table, event codes, slot counts and shared lane types.
// No dependencies.
package hkb_pkg;

    // Report shape and event budget
    localparam int KEY_SLOTS     = 6;
    localparam int TABLE_ENTRIES = 70;
    localparam int MAP_SIZE      = 70;
    localparam int EV_COUNT      = 2 * KEY_SLOTS + 4;
    localparam int CODE_W        = 7;
    localparam int USAGE_W       = 8;

    // Scancodes of the modifier keys
    localparam logic [CODE_W-1:0] SC_LSHIFT = 7'h2A;
    localparam logic [CODE_W-1:0] SC_RSHIFT = 7'h36;
    localparam logic [CODE_W-1:0] SC_CTRL   = 7'h1D;

    // Bits of the modifier byte
    localparam int MOD_LCTRL  = 0;
    localparam int MOD_LSHIFT = 1;
    localparam int MOD_RCTRL  = 4;
    localparam int MOD_RSHIFT = 5;

    typedef logic [KEY_SLOTS-1:0][USAGE_W-1:0] key_vec_t;

    // What one lane found for its slot
    typedef struct packed {
        logic              press_hit;
        logic [CODE_W-1:0] press_code;
        logic              rel_hit;
        logic [CODE_W-1:0] rel_code;
    } lane_res_t;

    typedef lane_res_t [KEY_SLOTS-1:0] lane_vec_t;

    // Usage to set 1 make code, zero where unmapped
    localparam logic [CODE_W-1:0] USAGE_MAP [MAP_SIZE] = '{
        7'd0,  7'd0,  7'd0,  7'd0,
        7'd30, 7'd48, 7'd46, 7'd32, 7'd18, 7'd33, 7'd34, 7'd35, 7'd23,
        7'd36, 7'd37, 7'd38, 7'd50,
        7'd49, 7'd24, 7'd25, 7'd16, 7'd19, 7'd31, 7'd20, 7'd22, 7'd47,
        7'd17, 7'd45, 7'd21, 7'd44,
        7'd2,  7'd3,  7'd4,  7'd5,  7'd6,  7'd7,  7'd8,  7'd9,  7'd10, 7'd11,
        7'd28, 7'd1,  7'd14, 7'd15, 7'd57, 7'd12, 7'd13, 7'd26, 7'd27, 7'd43,
        7'd43, 7'd39, 7'd40, 7'd41, 7'd51, 7'd52, 7'd53, 7'd58, 7'd59, 7'd60,
        7'd61,
        7'd62, 7'd63, 7'd64, 7'd65, 7'd66, 7'd67, 7'd68, 7'd87, 7'd88
    };

    function automatic logic [CODE_W-1:0] lookup(input logic [USAGE_W-1:0] usage);
        logic [CODE_W-1:0] code;
        code = '0;
        if ((32'(usage) < TABLE_ENTRIES) && (32'(usage) < MAP_SIZE)) begin
            code = USAGE_MAP[usage[CODE_W-1:0]];
        end
        return code;
    endfunction

endpackage

/* sv/hid_keyboard_report_to_scancodes_top.sv */
// Top level of the boot-keyboard report to scancode set 1 translator.
// Holds the previous report, the slot lanes and the merging stage.
// Depends on hkb_pkg, hkb_lane and hkb_merge.
//
// Usage:
//   The s_ channel takes one boot-keyboard report per transfer: the
//   modifier byte and six key usages. The m_ channel returns one set 1
//   event per transfer (make code, press or release, last-event flag).
//   Presses come first in slot order, then releases, then LShift, RShift,
//   LCtrl and RCtrl edges. An unchanged report produces no transfer.
//   The first event of a report passes from the pending event set into the
//   output register before it is offered. Events then leave at one per cycle
//   while m_ready is high, up to sixteen per report. The input is held while
//   the pending event set, drained one entry a cycle while the output
//   advances, still holds events.
//   Outside reset s_ready is high whenever the pending set is empty, so the
//   next report is taken while the last event of the previous one still waits.
//   Reset clears the stored report to all zero and empties the output.
//   A stall on m_ready holds the current event and the pending set.
module hid_keyboard_report_to_scancodes_top (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [7:0]                  s_modifier_bits,
    input  logic [7:0]                  s_key_slot_0,
    input  logic [7:0]                  s_key_slot_1,
    input  logic [7:0]                  s_key_slot_2,
    input  logic [7:0]                  s_key_slot_3,
    input  logic [7:0]                  s_key_slot_4,
    input  logic [7:0]                  s_key_slot_5,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [6:0]                  m_scan_code,
    output logic                        m_is_press,
    output logic                        m_last_event
);

    hkb_pkg::key_vec_t  new_keys;
    hkb_pkg::key_vec_t  prev_keys_reg;
    logic [7:0]         prev_mods_reg;
    hkb_pkg::lane_vec_t lanes;
    logic [3:0]         mod_hit;
    logic [3:0]         mod_press;
    logic               take;
    logic               busy;

    assign new_keys = {s_key_slot_5, s_key_slot_4, s_key_slot_3,
                       s_key_slot_2, s_key_slot_1, s_key_slot_0};

    assign s_ready = aresetn && !busy;
    assign take    = s_valid && s_ready;

    // Slot lanes
    for (genvar g = 0; g < hkb_pkg::KEY_SLOTS; g++) begin : g_lane
        hkb_lane u_lane (
            .new_key  (new_keys[g]),
            .old_key  (prev_keys_reg[g]),
            .new_keys (new_keys),
            .old_keys (prev_keys_reg),
            .res      (lanes[g])
        );
    end

    // Modifier edges in emission order
    assign mod_press = {s_modifier_bits[hkb_pkg::MOD_RCTRL],
                        s_modifier_bits[hkb_pkg::MOD_LCTRL],
                        s_modifier_bits[hkb_pkg::MOD_RSHIFT],
                        s_modifier_bits[hkb_pkg::MOD_LSHIFT]};
    assign mod_hit   = mod_press ^ {prev_mods_reg[hkb_pkg::MOD_RCTRL],
                                    prev_mods_reg[hkb_pkg::MOD_LCTRL],
                                    prev_mods_reg[hkb_pkg::MOD_RSHIFT],
                                    prev_mods_reg[hkb_pkg::MOD_LSHIFT]};

    // Replace the stored report on each transfer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_keys_reg <= '0;
            prev_mods_reg <= '0;
        end else if (take) begin
            prev_keys_reg <= new_keys;
            prev_mods_reg <= s_modifier_bits;
        end
    end

    hkb_merge u_merge (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .load         (take),
        .lanes        (lanes),
        .mod_hit      (mod_hit),
        .mod_press    (mod_press),
        .busy         (busy),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_scan_code  (m_scan_code),
        .m_is_press   (m_is_press),
        .m_last_event (m_last_event)
    );

endmodule

/* sv/hkb_lane.sv */
// One slot lane of the translator: press and release detection for a slot.
// Compares its new and old usage against the other report and maps them.
// Depends on hkb_pkg.
module hkb_lane (
    input  logic [hkb_pkg::USAGE_W-1:0] new_key,
    input  logic [hkb_pkg::USAGE_W-1:0] old_key,
    input  hkb_pkg::key_vec_t           new_keys,
    input  hkb_pkg::key_vec_t           old_keys,
    output hkb_pkg::lane_res_t          res
);

    logic in_old;
    logic in_new;
    logic [hkb_pkg::CODE_W-1:0] new_code;
    logic [hkb_pkg::CODE_W-1:0] old_code;

    // Search the other report for this slot's usages
    always_comb begin
        in_old = 1'b0;
        in_new = 1'b0;
        for (int j = 0; j < hkb_pkg::KEY_SLOTS; j++) begin
            if (old_keys[j] == new_key) in_old = 1'b1;
            if (new_keys[j] == old_key) in_new = 1'b1;
        end
    end

    assign new_code = hkb_pkg::lookup(new_key);
    assign old_code = hkb_pkg::lookup(old_key);

    // Report a press for a fresh key and a release for a vanished one
    assign res.press_hit  = (new_key != '0) && !in_old && (new_code != '0);
    assign res.press_code = new_code;
    assign res.rel_hit    = (old_key != '0) && !in_new && (old_code != '0);
    assign res.rel_code   = old_code;

endmodule

/* sv/hkb_merge.sv */
// Merging stage: gathers lane and modifier events into a pending set and
// sends them out lowest first through an output register. Depends on hkb_pkg.
module hkb_merge (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        load,
    input  hkb_pkg::lane_vec_t          lanes,
    input  logic [3:0]                  mod_hit,
    input  logic [3:0]                  mod_press,
    output logic                        busy,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [hkb_pkg::CODE_W-1:0]  m_scan_code,
    output logic                        m_is_press,
    output logic                        m_last_event
);

    localparam int N = hkb_pkg::EV_COUNT;
    localparam int K = hkb_pkg::KEY_SLOTS;

    logic [N-1:0]                 pend_reg;
    logic [N-1:0]                 pend_next;
    logic [hkb_pkg::CODE_W-1:0]   code_reg [N];
    logic [N-1:0]                 press_reg;
    logic [N-1:0]                 hit_in;
    logic [hkb_pkg::CODE_W-1:0]   code_in [N];
    logic [N-1:0]                 press_in;
    logic [N-1:0]                 pick;
    logic [hkb_pkg::CODE_W-1:0]   pick_code;
    logic                         pick_press;
    logic                         advance;
    logic                         out_valid_reg;
    logic [hkb_pkg::CODE_W-1:0]   out_code_reg;
    logic                         out_press_reg;
    logic                         out_last_reg;

    // Order events: presses, releases, then modifier edges
    always_comb begin
        for (int i = 0; i < K; i++) begin
            hit_in[i]       = lanes[i].press_hit;
            code_in[i]      = lanes[i].press_code;
            press_in[i]     = 1'b1;
            hit_in[K + i]   = lanes[i].rel_hit;
            code_in[K + i]  = lanes[i].rel_code;
            press_in[K + i] = 1'b0;
        end
        hit_in[2*K +: 4]   = mod_hit;
        press_in[2*K +: 4] = mod_press;
        code_in[2*K]       = hkb_pkg::SC_LSHIFT;
        code_in[2*K + 1]   = hkb_pkg::SC_RSHIFT;
        code_in[2*K + 2]   = hkb_pkg::SC_CTRL;
        code_in[2*K + 3]   = hkb_pkg::SC_CTRL;
    end

    // Isolate the lowest pending event and select its fields
    assign pick = pend_reg & (~pend_reg + N'(1));

    always_comb begin
        pick_code  = '0;
        pick_press = 1'b0;
        for (int i = 0; i < N; i++) begin
            if (pick[i]) begin
                pick_code  = pick_code | code_reg[i];
                pick_press = pick_press | press_reg[i];
            end
        end
    end

    assign advance = !out_valid_reg || m_ready;

    always_comb begin
        pend_next = pend_reg;
        if (load) begin
            pend_next = hit_in;
        end else if (advance) begin
            pend_next = pend_reg & ~pick;
        end
    end

    // Hold pending set and advance the output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            pend_reg <= pend_next;
            if (advance) begin
                out_valid_reg <= |pend_reg;
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (load) begin
            code_reg  <= code_in;
            press_reg <= press_in;
        end
        if (advance && (|pend_reg)) begin
            out_code_reg  <= pick_code;
            out_press_reg <= pick_press;
            out_last_reg  <= ((pend_reg & ~pick) == '0);
        end
    end

    assign busy         = |pend_reg;
    assign m_valid      = out_valid_reg;
    assign m_scan_code  = out_code_reg;
    assign m_is_press   = out_press_reg;
    assign m_last_event = out_last_reg;

endmodule

/* sv/hkb_checker.sv */
// Port-level checker for the translator top level, with its bind statement.
// Sees only the top level's ports. Depends on nothing else.
module hkb_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_ready,
    input logic       m_valid,
    input logic       m_ready,
    input logic [6:0] m_scan_code,
    input logic       m_is_press,
    input logic       m_last_event
);

    // Hold a stalled event
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_scan_code)
            && $stable(m_is_press) && $stable(m_last_event))
        else $error("stalled event changed");

    // Never send an empty make code
    a_code_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_scan_code != 7'd0)
        else $error("event with zero scancode");

    // Follow a non-final event with another at once
    a_burst: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_last_event |=> m_valid)
        else $error("gap inside an event burst");

    // Take no new report while a report still has events beyond the current one
    a_ready_burst: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_last_event |-> !s_ready)
        else $error("report accepted mid burst");

endmodule

bind hid_keyboard_report_to_scancodes_top hkb_checker u_hkb_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .s_ready      (s_ready),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_scan_code  (m_scan_code),
    .m_is_press   (m_is_press),
    .m_last_event (m_last_event)
);

/* bench/hkb_scancode_checker.sv */
// Scoreboard for the boot-keyboard report to scancode set 1 translator.
// Watches both channels, predicts the event stream of each report and compares.
// Depends on hkb_pkg for the slot count, table size, modifier bits and codes.
module hkb_scancode_checker (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    input  logic       s_ready,
    input  logic [7:0] s_modifier_bits,
    input  logic [7:0] s_key_slot_0,
    input  logic [7:0] s_key_slot_1,
    input  logic [7:0] s_key_slot_2,
    input  logic [7:0] s_key_slot_3,
    input  logic [7:0] s_key_slot_4,
    input  logic [7:0] s_key_slot_5,
    input  logic       m_valid,
    input  logic       m_ready,
    input  logic [6:0] m_scan_code,
    input  logic       m_is_press,
    input  logic       m_last_event,
    output int         mismatches,
    output int         events_due,
    output int         reports_taken,
    output int         events_checked
);

    typedef struct packed {
        logic [6:0] code;
        logic       press;
        logic       last;
    } key_event_t;

    // Usage to set 1 make code; zero marks an unmapped usage
    localparam int SET1_MAKE [hkb_pkg::TABLE_ENTRIES] = '{
        0, 0, 0, 0,
        30, 48, 46, 32, 18, 33, 34, 35, 23, 36, 37, 38, 50,
        49, 24, 25, 16, 19, 31, 20, 22, 47, 17, 45, 21, 44,
        2, 3, 4, 5, 6, 7, 8, 9, 10, 11,
        28, 1, 14, 15, 57, 12, 13, 26, 27, 43,
        43, 39, 40, 41, 51, 52, 53, 58, 59, 60, 61,
        62, 63, 64, 65, 66, 67, 68, 87, 88
    };

    localparam int PRINT_CAP = 40;

    logic [7:0]        held_mods;
    hkb_pkg::key_vec_t held_keys;
    key_event_t        report_events [$];
    key_event_t        due_events [$];
    int                fail_tally;
    int                report_tally;
    int                event_tally;
    hkb_pkg::key_vec_t offered_keys;

    assign offered_keys = {s_key_slot_5, s_key_slot_4, s_key_slot_3,
                           s_key_slot_2, s_key_slot_1, s_key_slot_0};

    task automatic report_mismatch(input string what);
        fail_tally++;
        if (fail_tally <= PRINT_CAP) begin
            $display("%0t scancode check: %s", $time, what);
        end
    endtask

    function automatic logic [6:0] make_code(input logic [7:0] usage);
        if (int'(usage) < hkb_pkg::TABLE_ENTRIES) begin
            return 7'(SET1_MAKE[usage[6:0]]);
        end
        return 7'd0;
    endfunction

    function automatic bit holds_usage(input hkb_pkg::key_vec_t keys,
                                       input logic [7:0] usage);
        for (int j = 0; j < hkb_pkg::KEY_SLOTS; j++) begin
            if (keys[j] == usage) begin
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    // A modifier only produces an event when its bit changes
    function automatic void note_modifier(input logic now, input logic was,
                                          input logic [6:0] code);
        if (now != was) begin
            report_events.push_back('{code, now, 1'b0});
        end
    endfunction

    // Work out the events of one report, then take it as the held report
    function automatic void predict_key_events(input logic [7:0] mods,
                                               input hkb_pkg::key_vec_t keys);
        logic [6:0] code;
        key_event_t ev;
        report_events.delete();
        // presses of usages that were not held before, in slot order
        for (int i = 0; i < hkb_pkg::KEY_SLOTS; i++) begin
            if (keys[i] != 8'd0 && !holds_usage(held_keys, keys[i])) begin
                code = make_code(keys[i]);
                if (code != 7'd0) begin
                    report_events.push_back('{code, 1'b1, 1'b0});
                end
            end
        end
        // releases of usages that have gone, in old slot order
        for (int i = 0; i < hkb_pkg::KEY_SLOTS; i++) begin
            if (held_keys[i] != 8'd0 && !holds_usage(keys, held_keys[i])) begin
                code = make_code(held_keys[i]);
                if (code != 7'd0) begin
                    report_events.push_back('{code, 1'b0, 1'b0});
                end
            end
        end
        note_modifier(mods[hkb_pkg::MOD_LSHIFT], held_mods[hkb_pkg::MOD_LSHIFT],
                      hkb_pkg::SC_LSHIFT);
        note_modifier(mods[hkb_pkg::MOD_RSHIFT], held_mods[hkb_pkg::MOD_RSHIFT],
                      hkb_pkg::SC_RSHIFT);
        note_modifier(mods[hkb_pkg::MOD_LCTRL], held_mods[hkb_pkg::MOD_LCTRL],
                      hkb_pkg::SC_CTRL);
        note_modifier(mods[hkb_pkg::MOD_RCTRL], held_mods[hkb_pkg::MOD_RCTRL],
                      hkb_pkg::SC_CTRL);
        // flag the final event and queue the lot
        for (int i = 0; i < report_events.size(); i++) begin
            ev = report_events[i];
            ev.last = (i == report_events.size() - 1);
            due_events.push_back(ev);
        end
        held_mods = mods;
        held_keys = keys;
    endfunction

    // Predict on each report transfer, compare on each event transfer
    always @(posedge aclk) begin
        key_event_t want;
        if (!aresetn) begin
            held_mods = 8'd0;
            held_keys = '0;
            due_events.delete();
        end else begin
            if (s_valid && s_ready) begin
                report_tally++;
                predict_key_events(s_modifier_bits, offered_keys);
            end
            if (m_valid && m_ready) begin
                event_tally++;
                if (due_events.size() == 0) begin
                    report_mismatch($sformatf("unexpected event code %02h press %b last %b",
                                              m_scan_code, m_is_press, m_last_event));
                end else begin
                    want = due_events.pop_front();
                    if (m_scan_code !== want.code) begin
                        report_mismatch($sformatf("scan_code %02h, expected %02h",
                                                  m_scan_code, want.code));
                    end
                    if (m_is_press !== want.press) begin
                        report_mismatch($sformatf("is_press %b, expected %b (code %02h)",
                                                  m_is_press, want.press, want.code));
                    end
                    if (m_last_event !== want.last) begin
                        report_mismatch($sformatf("last_event %b, expected %b (code %02h)",
                                                  m_last_event, want.last, want.code));
                    end
                end
            end
        end
        mismatches     <= fail_tally;
        events_due     <= due_events.size();
        reports_taken  <= report_tally;
        events_checked <= event_tally;
    end

endmodule

/* bench/hid_keyboard_report_to_scancodes_top_tb.sv */
// Testbench top for the boot-keyboard report to scancode set 1 translator.
// Drives directed and random keyboard reports, throttles the event side and
// gives the verdict. Depends on hkb_pkg, the block and hkb_scancode_checker.
module hid_keyboard_report_to_scancodes_top_tb;

    localparam int WATCHDOG_LIMIT = 1000;
    localparam int HOLD_CYCLES    = 80;
    localparam int SETTLE_CYCLES  = 20;
    localparam int RANDOM_REPORTS = 209;

    logic       aclk    = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    logic [7:0] s_modifier_bits = 8'd0;
    logic [7:0] s_key_slot_0 = 8'd0;
    logic [7:0] s_key_slot_1 = 8'd0;
    logic [7:0] s_key_slot_2 = 8'd0;
    logic [7:0] s_key_slot_3 = 8'd0;
    logic [7:0] s_key_slot_4 = 8'd0;
    logic [7:0] s_key_slot_5 = 8'd0;
    logic       m_valid;
    logic       m_ready = 1'b0;
    logic [6:0] m_scan_code;
    logic       m_is_press;
    logic       m_last_event;

    int mismatches;
    int events_due;
    int reports_taken;
    int events_checked;
    int quiet_cycles = 0;

    bit         gaps_on  = 1'b1;
    bit         hold_req = 1'b0;
    logic [7:0] cur_mods;
    logic [7:0] cur_keys [6];

    always #5 aclk = ~aclk;

    hid_keyboard_report_to_scancodes_top dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_modifier_bits (s_modifier_bits),
        .s_key_slot_0    (s_key_slot_0),
        .s_key_slot_1    (s_key_slot_1),
        .s_key_slot_2    (s_key_slot_2),
        .s_key_slot_3    (s_key_slot_3),
        .s_key_slot_4    (s_key_slot_4),
        .s_key_slot_5    (s_key_slot_5),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_scan_code     (m_scan_code),
        .m_is_press      (m_is_press),
        .m_last_event    (m_last_event)
    );

    hkb_scancode_checker scoreboard (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_modifier_bits (s_modifier_bits),
        .s_key_slot_0    (s_key_slot_0),
        .s_key_slot_1    (s_key_slot_1),
        .s_key_slot_2    (s_key_slot_2),
        .s_key_slot_3    (s_key_slot_3),
        .s_key_slot_4    (s_key_slot_4),
        .s_key_slot_5    (s_key_slot_5),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_scan_code     (m_scan_code),
        .m_is_press      (m_is_press),
        .m_last_event    (m_last_event),
        .mismatches      (mismatches),
        .events_due      (events_due),
        .reports_taken   (reports_taken),
        .events_checked  (events_checked)
    );

    // Event side: random back-pressure, or a long hold-off when asked
    initial begin
        forever begin
            @(posedge aclk);
            if (hold_req) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_req = 1'b0;
            end else begin
                m_ready <= !gaps_on || ($urandom_range(99) >= 21);
            end
        end
    end

    // Abort when no transfer happens on either channel for too long
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t watchdog: no transfer for %0d cycles", $time, quiet_cycles);
            $display("[hid_keyboard_report_to_scancodes_top] ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Offer one report and hold it until the transfer
    task automatic send_report(input logic [7:0] mods,
                               input logic [7:0] k0, input logic [7:0] k1,
                               input logic [7:0] k2, input logic [7:0] k3,
                               input logic [7:0] k4, input logic [7:0] k5);
        while (gaps_on && $urandom_range(99) < 21) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid         <= 1'b1;
        s_modifier_bits <= mods;
        s_key_slot_0    <= k0;
        s_key_slot_1    <= k1;
        s_key_slot_2    <= k2;
        s_key_slot_3    <= k3;
        s_key_slot_4    <= k4;
        s_key_slot_5    <= k5;
        do @(posedge aclk); while (!s_ready);
    endtask

    // Stop offering and wait for every outstanding event
    task automatic drain_events();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (events_due != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Mostly typing-like changes to the held report, some noise
    task automatic next_random_report();
        int pick;
        int slot;
        pick = $urandom_range(99);
        if (pick < 60) begin
            repeat ($urandom_range(1, 2)) begin
                slot = $urandom_range(5);
                cur_keys[slot] = ($urandom_range(3) == 0) ? 8'd0 : 8'($urandom_range(4, 69));
            end
            if ($urandom_range(2) == 0) begin
                cur_mods = cur_mods ^ (8'd1 << $urandom_range(7));
            end
        end else if (pick < 70) begin
            // resend unchanged
        end else if (pick < 76) begin
            cur_mods = 8'd0;
            foreach (cur_keys[i]) cur_keys[i] = 8'd0;
        end else if (pick < 84) begin
            // rotate slots: same keys, new order
            cur_keys = '{cur_keys[1], cur_keys[2], cur_keys[3],
                         cur_keys[4], cur_keys[5], cur_keys[0]};
        end else begin
            cur_mods = 8'($urandom_range(255));
            foreach (cur_keys[i]) cur_keys[i] = 8'($urandom_range(255));
        end
        send_report(cur_mods, cur_keys[0], cur_keys[1], cur_keys[2],
                    cur_keys[3], cur_keys[4], cur_keys[5]);
    endtask

    initial begin
        cur_mods = 8'd0;
        foreach (cur_keys[i]) cur_keys[i] = 8'd0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: empty report after reset, single press, no change
        send_report(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
        send_report(8'h00, 8'h04, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
        send_report(8'h00, 8'h04, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
        // Y, Z and non-US hash, then moved slots plus backslash
        send_report(8'h00, 8'h04, 8'h1C, 8'h1D, 8'h32, 8'h00, 8'h00);
        send_report(8'h00, 8'h31, 8'h04, 8'h1C, 8'h1D, 8'h32, 8'h00);
        // unmapped usages: zero entries and beyond the table
        send_report(8'h00, 8'h01, 8'h02, 8'h03, 8'h46, 8'h80, 8'hFF);
        // same usage in every slot
        send_report(8'h00, 8'h05, 8'h05, 8'h05, 8'h05, 8'h05, 8'h05);
        // full burst: six presses, six releases, four modifier presses
        send_report(8'hFF, 8'h04, 8'h27, 8'h28, 8'h29, 8'h44, 8'h45);
        // only the ignored modifier bits set
        send_report(8'hCC, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
        // each modifier on its own, both ctrl keys share a code
        send_report(8'h01, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
        send_report(8'h11, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
        send_report(8'h10, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
        send_report(8'h02, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
        send_report(8'h22, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
        send_report(8'h20, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
        send_report(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
        // all bits high everywhere
        send_report(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
        send_report(8'h33, 8'h1E, 8'h2D, 8'h39, 8'h3F, 8'h40, 8'h43);
        send_report(8'h33, 8'h43, 8'h40, 8'h3F, 8'h39, 8'h2D, 8'h1E);
        send_report(8'h00, 8'h2D, 8'h2D, 8'h00, 8'h00, 8'h00, 8'h00);
        send_report(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h45);
        drain_events();

        // Random: a quiet stretch, a long event hold-off and a full drain
        cur_keys[5] = 8'h45;
        for (int n = 0; n < RANDOM_REPORTS; n++) begin
            gaps_on = !(n >= 40 && n < 90);
            if (n == 120) begin
                hold_req = 1'b1;
            end
            if (n == 170) begin
                drain_events();
            end
            next_random_report();
        end
        drain_events();

        $display("Covered %0d reports and %0d events: table gaps, unmapped and repeated",
                 reports_taken, events_checked);
        $display("usages, sixteen-event bursts, modifier edges, back-pressure and a long stall.");
        if (mismatches == 0 && events_due == 0) begin
            $display("[hid_keyboard_report_to_scancodes_top] OK");
        end else begin
            $display("[hid_keyboard_report_to_scancodes_top] ERROR");
        end
        $finish;
    end

endmodule
